@@ hw/rtl/assert_macros.svh @@
// assertion macros included by the top-level layout file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
// same-cycle implication
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: same-cycle implication");
// next-cycle implication
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed: next-cycle implication");
`else
`define ASSERT_IMPLIES(label, clk, rst, ante, cons)
`define ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

@@ hw/rtl/fdl_pkg.sv @@
// constants, codes and shared types of the force-directed layout block
`default_nettype none
package fdl_pkg;

   localparam int MAX_VERTICES = 64;
   localparam int MAX_EDGES    = 128;
   localparam int VADDR_W      = $clog2(MAX_VERTICES);
   localparam int VCNT_W       = $clog2(MAX_VERTICES + 1);
   localparam int EADDR_W      = $clog2(MAX_EDGES);
   localparam int ECNT_W       = $clog2(MAX_EDGES + 1);
   localparam int COORD_W      = 24;
   localparam int CFG_W        = 23;
   localparam int PASS_W       = 10;
   localparam int WORD_W       = 64;
   localparam int STEP_W       = 6;

   localparam logic [CFG_W-1:0]  RST_K     = 23'd1638;
   localparam logic [CFG_W-1:0]  RST_TEMP  = 23'd6554;
   localparam logic [CFG_W-1:0]  RST_STEP  = 23'd16;
   localparam logic [PASS_W-1:0] RST_PASS  = 10'd400;

   localparam logic [WORD_W-1:0] Q_SAT     = (64'd1 << 38) - 64'd1;
   localparam logic [WORD_W-1:0] NORM_LIM  = 64'd1 << 30;
   localparam logic [WORD_W-1:0] SQRT_TOP  = 64'd1 << 62;

   typedef enum logic [1:0] {
      OP_LOAD_VERTEX = 2'd0,
      OP_LOAD_EDGE   = 2'd1,
      OP_START       = 2'd2,
      OP_CLEAR       = 2'd3
   } fdl_opcode_type;

   typedef enum logic [1:0] {
      CSR_K     = 2'd0,
      CSR_TEMP  = 2'd1,
      CSR_STEP  = 2'd2,
      CSR_PASS  = 2'd3
   } fdl_csr_type;

   typedef enum logic [1:0] {
      ALU_MUL  = 2'd0,
      ALU_DIV  = 2'd1,
      ALU_SQRT = 2'd2
   } fdl_alu_op_type;

   typedef struct packed {
      logic                start;
      fdl_alu_op_type      op;
      logic [WORD_W-1:0]   opa;
      logic [WORD_W-1:0]   opb;
   } fdl_alu_req_type;

   typedef struct packed {
      logic                busy;
      logic                done;
      logic [WORD_W-1:0]   result;
   } fdl_alu_rsp_type;

   typedef enum logic [5:0] {
      ST_IDLE, ST_K2, ST_V_READ, ST_V_LOAD,
      ST_U_CHECK, ST_U_LOAD, ST_U_SQX, ST_U_SQY, ST_U_DIV, ST_U_FX, ST_U_FY,
      ST_E_CHECK, ST_E_LOAD, ST_E_WREAD, ST_E_SQX, ST_E_SQY, ST_E_SQRT,
      ST_E_MX, ST_E_DX, ST_E_MY, ST_E_DY,
      ST_M_MAG, ST_M_CHECK, ST_M_SQX, ST_M_SQY, ST_M_TT, ST_M_NORM,
      ST_M_BX, ST_M_BY, ST_M_LEN, ST_M_MX, ST_M_DX, ST_M_MY, ST_M_DY,
      ST_M_WRITE, ST_M_NEXT,
      ST_O_READ, ST_O_LOAD, ST_O_WAIT
   } fdl_state_type;

endpackage
`default_nettype wire

@@ hw/rtl/fdl_if.sv @@
// request and response channel interfaces
`default_nettype none
interface fdl_req_if;
   logic                valid;
   logic                ready;
   logic [1:0]          opcode;
   logic signed [23:0]  pos_x;
   logic signed [23:0]  pos_y;
   logic [5:0]          end_a;
   logic [5:0]          end_b;
   modport source (output valid, opcode, pos_x, pos_y, end_a, end_b, input ready);
   modport sink   (input valid, opcode, pos_x, pos_y, end_a, end_b, output ready);
endinterface

interface fdl_rsp_if;
   logic                valid;
   logic                ready;
   logic [5:0]          vertex_index;
   logic signed [23:0]  out_x;
   logic signed [23:0]  out_y;
   logic                last;
   modport source (output valid, vertex_index, out_x, out_y, last, input ready);
   modport sink   (input valid, vertex_index, out_x, out_y, last, output ready);
endinterface
`default_nettype wire

@@ hw/rtl/fdl_ram.sv @@
// generic single-port-write ram with registered read
`default_nettype none
module fdl_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule
`default_nettype wire

@@ hw/rtl/fdl_alu.sv @@
// shared iterative unit: shift-add multiply, restoring divide, integer square root
`default_nettype none
module fdl_alu (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire fdl_pkg::fdl_alu_req_type req,
   output fdl_pkg::fdl_alu_rsp_type      rsp
);
   logic                          busy_ff, busy_in;
   logic                          done_ff, done_in;
   fdl_pkg::fdl_alu_op_type       op_ff, op_in;
   logic [fdl_pkg::STEP_W-1:0]    cnt_ff, cnt_in;
   logic [fdl_pkg::WORD_W-1:0]    acc_ff, acc_in;
   logic [fdl_pkg::WORD_W-1:0]    opa_ff, opa_in;
   logic [fdl_pkg::WORD_W-1:0]    opb_ff, opb_in;
   logic [fdl_pkg::WORD_W-1:0]    rem_ff, rem_in;
   logic [fdl_pkg::WORD_W:0]      trial;
   logic [fdl_pkg::WORD_W-1:0]    root_try;
   logic                          last_step;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      op_ff  <= op_in;
      cnt_ff <= cnt_in;
      acc_ff <= acc_in;
      opa_ff <= opa_in;
      opb_ff <= opb_in;
      rem_ff <= rem_in;
   end

   // square root takes one bit pair a step, the others one bit
   assign last_step = (op_ff == fdl_pkg::ALU_SQRT) ? (cnt_ff == 6'd31) : (cnt_ff == 6'd63);
   assign trial     = {rem_ff, opa_ff[fdl_pkg::WORD_W-1]};
   assign root_try  = acc_ff + opb_ff;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      op_in   = op_ff;
      cnt_in  = cnt_ff;
      acc_in  = acc_ff;
      opa_in  = opa_ff;
      opb_in  = opb_ff;
      rem_in  = rem_ff;
      if (req.start) begin
         busy_in = 1'b1;
         op_in   = req.op;
         cnt_in  = '0;
         acc_in  = '0;
         rem_in  = '0;
         opa_in  = req.opa;
         case (req.op)
            fdl_pkg::ALU_SQRT: opb_in = fdl_pkg::SQRT_TOP;
            default:           opb_in = req.opb;
         endcase
      end else if (busy_ff) begin
         cnt_in = cnt_ff + 6'd1;
         case (op_ff)
            fdl_pkg::ALU_MUL: begin
               if (opb_ff[0]) begin
                  acc_in = acc_ff + opa_ff;
               end
               opa_in = {opa_ff[fdl_pkg::WORD_W-2:0], 1'b0};
               opb_in = {1'b0, opb_ff[fdl_pkg::WORD_W-1:1]};
            end
            fdl_pkg::ALU_DIV: begin
               if (trial >= {1'b0, opb_ff}) begin
                  rem_in = fdl_pkg::WORD_W'(trial - {1'b0, opb_ff});
                  acc_in = {acc_ff[fdl_pkg::WORD_W-2:0], 1'b1};
               end else begin
                  rem_in = trial[fdl_pkg::WORD_W-1:0];
                  acc_in = {acc_ff[fdl_pkg::WORD_W-2:0], 1'b0};
               end
               opa_in = {opa_ff[fdl_pkg::WORD_W-2:0], 1'b0};
            end
            fdl_pkg::ALU_SQRT: begin
               if (opa_ff >= root_try) begin
                  opa_in = opa_ff - root_try;
                  acc_in = {1'b0, acc_ff[fdl_pkg::WORD_W-1:1]} + opb_ff;
               end else begin
                  acc_in = {1'b0, acc_ff[fdl_pkg::WORD_W-1:1]};
               end
               opb_in = {2'b00, opb_ff[fdl_pkg::WORD_W-1:2]};
            end
            default: begin
               busy_in = 1'b0;
            end
         endcase
         if (last_step) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   assign rsp.busy   = busy_ff;
   assign rsp.done   = done_ff;
   assign rsp.result = acc_ff;
endmodule
`default_nettype wire

@@ hw/rtl/force_directed_graph_layout.sv @@
// top level of the force-directed (fruchterman-reingold) graph layout block
`default_nettype none
`include "assert_macros.svh"
//
// channel   dir   beat                                         handshake
// req_bus   in    opcode, pos_x, pos_y, end_a, end_b            valid/ready
// rsp_bus   out   vertex_index, out_x, out_y, last              valid/ready
// csr_*     in    csr_index, csr_write_data                     csr_write_en, no wait
//
// load and clear beats are accepted back to back while idle
// a start beat runs pass_count passes; the run time of one pass grows with vertices squared
// and with the number of edge visits, and is set by the shared iterative alu
// (64 steps per multiply or divide, 32 per square root) that every force term uses
// after the passes the result beats leave one at a time, each held until rsp ready
// synchronous active-high reset clears counts, state and the alu and loads the csr defaults; stores keep contents
// req_ready is low from the start beat until the last result beat is taken, or the run ends with no vertices
//
module force_directed_graph_layout (
   input  wire logic                       clock,
   input  wire logic                       reset,
   fdl_req_if.sink                         req_bus,
   fdl_rsp_if.source                       rsp_bus,
   input  wire logic                       csr_write_en,
   input  wire logic [1:0]                 csr_index,
   input  wire logic [fdl_pkg::CFG_W-1:0]  csr_write_data
);
   localparam int VW = fdl_pkg::VADDR_W;
   localparam int CW = fdl_pkg::COORD_W;
   localparam int WW = fdl_pkg::WORD_W;

   // configuration registers
   logic [fdl_pkg::CFG_W-1:0]   cfg_k_ff, cfg_temp_ff, cfg_step_ff;
   logic [fdl_pkg::PASS_W-1:0]  cfg_pass_ff;

   // sequencer state
   fdl_pkg::fdl_state_type      state_ff, state_in;
   logic [fdl_pkg::VCNT_W-1:0]  vcnt_ff, vcnt_in;
   logic [fdl_pkg::ECNT_W-1:0]  ecnt_ff, ecnt_in;
   logic [CW-1:0]               temp_ff, temp_in;
   logic [45:0]                 k2_ff, k2_in;
   logic [fdl_pkg::PASS_W-1:0]  pass_ff, pass_in;
   logic [fdl_pkg::VCNT_W-1:0]  v_ff, v_in;
   logic [fdl_pkg::VCNT_W-1:0]  u_ff, u_in;
   logic [fdl_pkg::ECNT_W-1:0]  e_ff, e_in;

   // datapath registers
   logic [CW-1:0]               vx_ff, vx_in, vy_ff, vy_in;
   logic [WW-1:0]               sx_ff, sx_in, sy_ff, sy_in;
   logic [WW-1:0]               magx_ff, magx_in, magy_ff, magy_in;
   logic                        negx_ff, negx_in, negy_ff, negy_in;
   logic [WW-1:0]               tmp_ff, tmp_in;
   logic [WW-1:0]               fac_ff, fac_in;
   logic [CW:0]                 mx_ff, mx_in, my_ff, my_in;

   // result register
   logic                        rsp_valid_ff, rsp_valid_in;
   logic [VW-1:0]               rsp_idx_ff, rsp_idx_in;
   logic [CW-1:0]               rsp_x_ff, rsp_x_in, rsp_y_ff, rsp_y_in;
   logic                        rsp_last_ff, rsp_last_in;

   // memories and alu
   logic                        vram_we;
   logic [VW-1:0]               vram_waddr, vram_raddr;
   logic [2*CW-1:0]             vram_wdata, vram_rdata;
   logic                        eram_we;
   logic [fdl_pkg::EADDR_W-1:0] eram_waddr, eram_raddr;
   logic [2*VW-1:0]             eram_wdata, eram_rdata;
   fdl_pkg::fdl_alu_req_type    alu_req;
   fdl_pkg::fdl_alu_rsp_type    alu_rsp;

   logic [CW-1:0]               rd_x, rd_y;
   logic [CW-2:0]               k_eff;
   logic [WW-1:0]               t64;
   logic                        req_fire;

   function automatic fdl_pkg::fdl_alu_req_type alu_cmd(
      input fdl_pkg::fdl_alu_op_type op, input logic [WW-1:0] a, input logic [WW-1:0] b);
      fdl_pkg::fdl_alu_req_type r;
      r.start = 1'b1;
      r.op    = op;
      r.opa   = a;
      r.opb   = b;
      return r;
   endfunction

   function automatic logic [CW-1:0] sat_coord(input logic [CW+1:0] s);
      logic [CW-1:0] r;
      if (s[CW+1:CW-1] == 3'b000 || s[CW+1:CW-1] == 3'b111) begin
         r = s[CW-1:0];
      end else if (s[CW+1]) begin
         r = {1'b1, {(CW-1){1'b0}}};
      end else begin
         r = {1'b0, {(CW-1){1'b1}}};
      end
      return r;
   endfunction

   fdl_ram #(.WIDTH(2*CW), .DEPTH(fdl_pkg::MAX_VERTICES)) u_vertex_ram (
      .clock   (clock),
      .wr_en   (vram_we),
      .wr_addr (vram_waddr),
      .wr_data (vram_wdata),
      .rd_addr (vram_raddr),
      .rd_data (vram_rdata)
   );

   fdl_ram #(.WIDTH(2*VW), .DEPTH(fdl_pkg::MAX_EDGES)) u_edge_ram (
      .clock   (clock),
      .wr_en   (eram_we),
      .wr_addr (eram_waddr),
      .wr_data (eram_wdata),
      .rd_addr (eram_raddr),
      .rd_data (eram_rdata)
   );

   fdl_alu u_alu (
      .clock (clock),
      .reset (reset),
      .req   (alu_req),
      .rsp   (alu_rsp)
   );

   assign rd_x     = vram_rdata[2*CW-1:CW];
   assign rd_y     = vram_rdata[CW-1:0];
   assign k_eff    = (cfg_k_ff == '0) ? 23'd1 : cfg_k_ff;   // zero k acts as one
   assign t64      = {{(WW-CW){1'b0}}, temp_ff};
   assign req_bus.ready = (state_ff == fdl_pkg::ST_IDLE);
   assign req_fire = req_bus.valid && req_bus.ready;

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_k_ff    <= fdl_pkg::RST_K;
         cfg_temp_ff <= fdl_pkg::RST_TEMP;
         cfg_step_ff <= fdl_pkg::RST_STEP;
         cfg_pass_ff <= fdl_pkg::RST_PASS;
      end else if (csr_write_en) begin
         case (csr_index)
            fdl_pkg::CSR_K:    cfg_k_ff    <= csr_write_data;
            fdl_pkg::CSR_TEMP: cfg_temp_ff <= csr_write_data;
            fdl_pkg::CSR_STEP: cfg_step_ff <= csr_write_data;
            fdl_pkg::CSR_PASS: cfg_pass_ff <= csr_write_data[fdl_pkg::PASS_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= fdl_pkg::ST_IDLE;
         vcnt_ff      <= '0;
         ecnt_ff      <= '0;
         temp_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         vcnt_ff      <= vcnt_in;
         ecnt_ff      <= ecnt_in;
         temp_ff      <= temp_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      k2_ff       <= k2_in;
      pass_ff     <= pass_in;
      v_ff        <= v_in;
      u_ff        <= u_in;
      e_ff        <= e_in;
      vx_ff       <= vx_in;
      vy_ff       <= vy_in;
      sx_ff       <= sx_in;
      sy_ff       <= sy_in;
      magx_ff     <= magx_in;
      magy_ff     <= magy_in;
      negx_ff     <= negx_in;
      negy_ff     <= negy_in;
      tmp_ff      <= tmp_in;
      fac_ff      <= fac_in;
      mx_ff       <= mx_in;
      my_ff       <= my_in;
      rsp_idx_ff  <= rsp_idx_in;
      rsp_x_ff    <= rsp_x_in;
      rsp_y_ff    <= rsp_y_in;
      rsp_last_ff <= rsp_last_in;
   end

   always_comb begin
      logic [CW:0]   dx25, dy25, mag25x, mag25y, r25;
      logic [WW-1:0] sum64, q64;
      logic [VW-1:0] ea, eb;
      logic          skip_edge;

      state_in     = state_ff;
      vcnt_in      = vcnt_ff;
      ecnt_in      = ecnt_ff;
      temp_in      = temp_ff;
      k2_in        = k2_ff;
      pass_in      = pass_ff;
      v_in         = v_ff;
      u_in         = u_ff;
      e_in         = e_ff;
      vx_in        = vx_ff;
      vy_in        = vy_ff;
      sx_in        = sx_ff;
      sy_in        = sy_ff;
      magx_in      = magx_ff;
      magy_in      = magy_ff;
      negx_in      = negx_ff;
      negy_in      = negy_ff;
      tmp_in       = tmp_ff;
      fac_in       = fac_ff;
      mx_in        = mx_ff;
      my_in        = my_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_idx_in   = rsp_idx_ff;
      rsp_x_in     = rsp_x_ff;
      rsp_y_in     = rsp_y_ff;
      rsp_last_in  = rsp_last_ff;

      vram_we      = 1'b0;
      vram_waddr   = vcnt_ff[VW-1:0];
      vram_wdata   = {req_bus.pos_x, req_bus.pos_y};
      vram_raddr   = v_ff[VW-1:0];
      eram_we      = 1'b0;
      eram_waddr   = ecnt_ff[fdl_pkg::EADDR_W-1:0];
      eram_wdata   = {req_bus.end_a, req_bus.end_b};
      eram_raddr   = e_ff[fdl_pkg::EADDR_W-1:0];

      alu_req.start = 1'b0;
      alu_req.op    = fdl_pkg::ALU_MUL;
      alu_req.opa   = '0;
      alu_req.opb   = '0;

      // coordinate difference of the held vertex against the read one
      dx25   = {vx_ff[CW-1], vx_ff} - {rd_x[CW-1], rd_x};
      dy25   = {vy_ff[CW-1], vy_ff} - {rd_y[CW-1], rd_y};
      mag25x = dx25[CW] ? -dx25 : dx25;
      mag25y = dy25[CW] ? -dy25 : dy25;
      sum64  = tmp_ff + alu_rsp.result;
      q64    = (alu_rsp.result > fdl_pkg::Q_SAT) ? fdl_pkg::Q_SAT : alu_rsp.result;
      r25    = alu_rsp.result[CW:0];
      ea     = eram_rdata[2*VW-1:VW];
      eb     = eram_rdata[VW-1:0];
      skip_edge = ({1'b0, ea} >= vcnt_ff) || ({1'b0, eb} >= vcnt_ff) || (ea == eb) ||
                  ((ea != v_ff[VW-1:0]) && (eb != v_ff[VW-1:0]));

      case (state_ff)
         fdl_pkg::ST_IDLE: begin
            if (req_fire) begin
               case (req_bus.opcode)
                  fdl_pkg::OP_LOAD_VERTEX: begin
                     if (vcnt_ff < fdl_pkg::VCNT_W'(fdl_pkg::MAX_VERTICES)) begin
                        vram_we = 1'b1;
                        vcnt_in = vcnt_ff + 1'b1;
                     end
                  end
                  fdl_pkg::OP_LOAD_EDGE: begin
                     if (ecnt_ff < fdl_pkg::ECNT_W'(fdl_pkg::MAX_EDGES)) begin
                        eram_we = 1'b1;
                        ecnt_in = ecnt_ff + 1'b1;
                     end
                  end
                  fdl_pkg::OP_CLEAR: begin
                     vcnt_in = '0;
                     ecnt_in = '0;
                  end
                  default: begin
                     temp_in  = {1'b0, cfg_temp_ff};
                     alu_req  = alu_cmd(fdl_pkg::ALU_MUL, WW'(k_eff), WW'(k_eff));
                     state_in = fdl_pkg::ST_K2;
                  end
               endcase
            end
         end
         fdl_pkg::ST_K2: begin
            if (alu_rsp.done) begin
               k2_in   = alu_rsp.result[45:0];
               pass_in = '0;
               v_in    = '0;
               if (cfg_pass_ff == '0 || vcnt_ff == '0) begin
                  state_in = fdl_pkg::ST_O_READ;
               end else begin
                  state_in = fdl_pkg::ST_V_READ;
               end
            end
         end
         fdl_pkg::ST_V_READ: begin
            state_in = fdl_pkg::ST_V_LOAD;
         end
         fdl_pkg::ST_V_LOAD: begin
            vx_in    = rd_x;
            vy_in    = rd_y;
            sx_in    = '0;
            sy_in    = '0;
            u_in     = '0;
            state_in = fdl_pkg::ST_U_CHECK;
         end
         // repulsion from every other vertex
         fdl_pkg::ST_U_CHECK: begin
            vram_raddr = u_ff[VW-1:0];
            if (u_ff == vcnt_ff) begin
               e_in     = '0;
               state_in = fdl_pkg::ST_E_CHECK;
            end else if (u_ff == v_ff) begin
               u_in = u_ff + 1'b1;
            end else begin
               state_in = fdl_pkg::ST_U_LOAD;
            end
         end
         fdl_pkg::ST_U_LOAD: begin
            magx_in  = WW'(mag25x);
            magy_in  = WW'(mag25y);
            negx_in  = dx25[CW];
            negy_in  = dy25[CW];
            alu_req  = alu_cmd(fdl_pkg::ALU_MUL, WW'(mag25x), WW'(mag25x));
            state_in = fdl_pkg::ST_U_SQX;
         end
         fdl_pkg::ST_U_SQX: begin
            if (alu_rsp.done) begin
               tmp_in   = alu_rsp.result;
               alu_req  = alu_cmd(fdl_pkg::ALU_MUL, magy_ff, magy_ff);
               state_in = fdl_pkg::ST_U_SQY;
            end
         end
         fdl_pkg::ST_U_SQY: begin
            if (alu_rsp.done) begin
               if (sum64 == '0) begin
                  // coincident vertices add no force
                  u_in     = u_ff + 1'b1;
                  state_in = fdl_pkg::ST_U_CHECK;
               end else begin
                  alu_req  = alu_cmd(fdl_pkg::ALU_DIV, {2'b00, k2_ff, 16'd0}, sum64);
                  state_in = fdl_pkg::ST_U_DIV;
               end
            end
         end
         fdl_pkg::ST_U_DIV: begin
            if (alu_rsp.done) begin
               fac_in   = q64;
               alu_req  = alu_cmd(fdl_pkg::ALU_MUL, magx_ff, q64);
               state_in = fdl_pkg::ST_U_FX;
            end
         end
         fdl_pkg::ST_U_FX: begin
            if (alu_rsp.done) begin
               sx_in    = negx_ff ? sx_ff - (alu_rsp.result >> 16)
                                  : sx_ff + (alu_rsp.result >> 16);
               alu_req  = alu_cmd(fdl_pkg::ALU_MUL, magy_ff, fac_ff);
               state_in = fdl_pkg::ST_U_FY;
            end
         end
         fdl_pkg::ST_U_FY: begin
            if (alu_rsp.done) begin
               sy_in    = negy_ff ? sy_ff - (alu_rsp.result >> 16)
                                  : sy_ff + (alu_rsp.result >> 16);
               u_in     = u_ff + 1'b1;
               state_in = fdl_pkg::ST_U_CHECK;
            end
         end
         // attraction along incident edges
         fdl_pkg::ST_E_CHECK: begin
            if (e_ff == ecnt_ff) begin
               state_in = fdl_pkg::ST_M_MAG;
            end else begin
               state_in = fdl_pkg::ST_E_LOAD;
            end
         end
         fdl_pkg::ST_E_LOAD: begin
            vram_raddr = (ea == v_ff[VW-1:0]) ? eb : ea;
            if (skip_edge) begin
               e_in     = e_ff + 1'b1;
               state_in = fdl_pkg::ST_E_CHECK;
            end else begin
               state_in = fdl_pkg::ST_E_WREAD;
            end
         end
         fdl_pkg::ST_E_WREAD: begin
            magx_in  = WW'(mag25x);
            magy_in  = WW'(mag25y);
            negx_in  = dx25[CW];
            negy_in  = dy25[CW];
            alu_req  = alu_cmd(fdl_pkg::ALU_MUL, WW'(mag25x), WW'(mag25x));
            state_in = fdl_pkg::ST_E_SQX;
         end
         fdl_pkg::ST_E_SQX: begin
            if (alu_rsp.done) begin
               tmp_in   = alu_rsp.result;
               alu_req  = alu_cmd(fdl_pkg::ALU_MUL, magy_ff, magy_ff);
               state_in = fdl_pkg::ST_E_SQY;
            end
         end
         fdl_pkg::ST_E_SQY: begin
            if (alu_rsp.done) begin
               alu_req  = alu_cmd(fdl_pkg::ALU_SQRT, sum64, '0);
               state_in = fdl_pkg::ST_E_SQRT;
            end
         end
         fdl_pkg::ST_E_SQRT: begin
            if (alu_rsp.done) begin
               fac_in   = alu_rsp.result;
               alu_req  = alu_cmd(fdl_pkg::ALU_MUL, magx_ff, alu_rsp.result);
               state_in = fdl_pkg::ST_E_MX;
            end
         end
         fdl_pkg::ST_E_MX: begin
            if (alu_rsp.done) begin
               alu_req  = alu_cmd(fdl_pkg::ALU_DIV, alu_rsp.result, WW'(k_eff));
               state_in = fdl_pkg::ST_E_DX;
            end
         end
         fdl_pkg::ST_E_DX: begin
            if (alu_rsp.done) begin
               sx_in    = negx_ff ? sx_ff + alu_rsp.result : sx_ff - alu_rsp.result;
               alu_req  = alu_cmd(fdl_pkg::ALU_MUL, magy_ff, fac_ff);
               state_in = fdl_pkg::ST_E_MY;
            end
         end
         fdl_pkg::ST_E_MY: begin
            if (alu_rsp.done) begin
               alu_req  = alu_cmd(fdl_pkg::ALU_DIV, alu_rsp.result, WW'(k_eff));
               state_in = fdl_pkg::ST_E_DY;
            end
         end
         fdl_pkg::ST_E_DY: begin
            if (alu_rsp.done) begin
               sy_in    = negy_ff ? sy_ff + alu_rsp.result : sy_ff - alu_rsp.result;
               e_in     = e_ff + 1'b1;
               state_in = fdl_pkg::ST_E_CHECK;
            end
         end
         // cap the displacement at the temperature
         fdl_pkg::ST_M_MAG: begin
            negx_in  = sx_ff[WW-1];
            negy_in  = sy_ff[WW-1];
            magx_in  = sx_ff[WW-1] ? -sx_ff : sx_ff;
            magy_in  = sy_ff[WW-1] ? -sy_ff : sy_ff;
            state_in = fdl_pkg::ST_M_CHECK;
         end
         fdl_pkg::ST_M_CHECK: begin
            if (magx_ff == '0 && magy_ff == '0) begin
               state_in = fdl_pkg::ST_M_NEXT;
            end else if (magx_ff <= t64 && magy_ff <= t64) begin
               alu_req  = alu_cmd(fdl_pkg::ALU_MUL, magx_ff, magx_ff);
               state_in = fdl_pkg::ST_M_SQX;
            end else begin
               state_in = fdl_pkg::ST_M_NORM;
            end
         end
         fdl_pkg::ST_M_SQX: begin
            if (alu_rsp.done) begin
               tmp_in   = alu_rsp.result;
               alu_req  = alu_cmd(fdl_pkg::ALU_MUL, magy_ff, magy_ff);
               state_in = fdl_pkg::ST_M_SQY;
            end
         end
         fdl_pkg::ST_M_SQY: begin
            if (alu_rsp.done) begin
               tmp_in   = sum64;
               alu_req  = alu_cmd(fdl_pkg::ALU_MUL, t64, t64);
               state_in = fdl_pkg::ST_M_TT;
            end
         end
         fdl_pkg::ST_M_TT: begin
            if (alu_rsp.done) begin
               if (tmp_ff <= alu_rsp.result) begin
                  mx_in    = sx_ff[CW:0];
                  my_in    = sy_ff[CW:0];
                  state_in = fdl_pkg::ST_M_WRITE;
               end else begin
                  state_in = fdl_pkg::ST_M_NORM;
               end
            end
         end
         fdl_pkg::ST_M_NORM: begin
            // one right shift a cycle until both parts sit below the limit
            if (magx_ff >= fdl_pkg::NORM_LIM || magy_ff >= fdl_pkg::NORM_LIM) begin
               magx_in = magx_ff >> 1;
               magy_in = magy_ff >> 1;
            end else begin
               alu_req  = alu_cmd(fdl_pkg::ALU_MUL, magx_ff, magx_ff);
               state_in = fdl_pkg::ST_M_BX;
            end
         end
         fdl_pkg::ST_M_BX: begin
            if (alu_rsp.done) begin
               tmp_in   = alu_rsp.result;
               alu_req  = alu_cmd(fdl_pkg::ALU_MUL, magy_ff, magy_ff);
               state_in = fdl_pkg::ST_M_BY;
            end
         end
         fdl_pkg::ST_M_BY: begin
            if (alu_rsp.done) begin
               alu_req  = alu_cmd(fdl_pkg::ALU_SQRT, sum64, '0);
               state_in = fdl_pkg::ST_M_LEN;
            end
         end
         fdl_pkg::ST_M_LEN: begin
            if (alu_rsp.done) begin
               if (alu_rsp.result == '0) begin
                  state_in = fdl_pkg::ST_M_NEXT;
               end else begin
                  fac_in   = alu_rsp.result;
                  alu_req  = alu_cmd(fdl_pkg::ALU_MUL, magx_ff, t64);
                  state_in = fdl_pkg::ST_M_MX;
               end
            end
         end
         fdl_pkg::ST_M_MX: begin
            if (alu_rsp.done) begin
               alu_req  = alu_cmd(fdl_pkg::ALU_DIV, alu_rsp.result, fac_ff);
               state_in = fdl_pkg::ST_M_DX;
            end
         end
         fdl_pkg::ST_M_DX: begin
            if (alu_rsp.done) begin
               mx_in    = negx_ff ? -r25 : r25;
               alu_req  = alu_cmd(fdl_pkg::ALU_MUL, magy_ff, t64);
               state_in = fdl_pkg::ST_M_MY;
            end
         end
         fdl_pkg::ST_M_MY: begin
            if (alu_rsp.done) begin
               alu_req  = alu_cmd(fdl_pkg::ALU_DIV, alu_rsp.result, fac_ff);
               state_in = fdl_pkg::ST_M_DY;
            end
         end
         fdl_pkg::ST_M_DY: begin
            if (alu_rsp.done) begin
               my_in    = negy_ff ? -r25 : r25;
               state_in = fdl_pkg::ST_M_WRITE;
            end
         end
         fdl_pkg::ST_M_WRITE: begin
            // written back in place so later vertices of the pass see it
            vram_we    = 1'b1;
            vram_waddr = v_ff[VW-1:0];
            vram_wdata = {sat_coord({mx_ff[CW], mx_ff} + {{2{vx_ff[CW-1]}}, vx_ff}),
                          sat_coord({my_ff[CW], my_ff} + {{2{vy_ff[CW-1]}}, vy_ff})};
            state_in   = fdl_pkg::ST_M_NEXT;
         end
         fdl_pkg::ST_M_NEXT: begin
            if (v_ff + 1'b1 == vcnt_ff) begin
               v_in    = '0;
               pass_in = pass_ff + 1'b1;
               temp_in = (temp_ff > {1'b0, cfg_step_ff}) ? temp_ff - {1'b0, cfg_step_ff} : '0;
               if (pass_ff + 1'b1 == cfg_pass_ff) begin
                  state_in = fdl_pkg::ST_O_READ;
               end else begin
                  state_in = fdl_pkg::ST_V_READ;
               end
            end else begin
               v_in     = v_ff + 1'b1;
               state_in = fdl_pkg::ST_V_READ;
            end
         end
         // stream out the final positions
         fdl_pkg::ST_O_READ: begin
            if (v_ff == vcnt_ff) begin
               state_in = fdl_pkg::ST_IDLE;
            end else begin
               state_in = fdl_pkg::ST_O_LOAD;
            end
         end
         fdl_pkg::ST_O_LOAD: begin
            rsp_valid_in = 1'b1;
            rsp_idx_in   = v_ff[VW-1:0];
            rsp_x_in     = rd_x;
            rsp_y_in     = rd_y;
            rsp_last_in  = (v_ff + 1'b1 == vcnt_ff);
            state_in     = fdl_pkg::ST_O_WAIT;
         end
         fdl_pkg::ST_O_WAIT: begin
            if (rsp_bus.ready) begin
               rsp_valid_in = 1'b0;
               v_in         = v_ff + 1'b1;
               state_in     = rsp_last_ff ? fdl_pkg::ST_IDLE : fdl_pkg::ST_O_READ;
            end
         end
         default: begin
            state_in = fdl_pkg::ST_IDLE;
         end
      endcase
   end

   assign rsp_bus.valid        = rsp_valid_ff;
   assign rsp_bus.vertex_index = rsp_idx_ff;
   assign rsp_bus.out_x        = rsp_x_ff;
   assign rsp_bus.out_y        = rsp_y_ff;
   assign rsp_bus.last         = rsp_last_ff;

   // a pending result beat always keeps the request side closed
   `ASSERT_IMPLIES(a_rsp_blocks_req, clock, reset, rsp_bus.valid, !req_bus.ready)
   // the alu is only started when it is free
   `ASSERT_IMPLIES(a_alu_start_idle, clock, reset, alu_req.start, !alu_rsp.busy)
   // the last result beat ends the run
   `ASSERT_NEXT(a_last_ends_run, clock, reset, rsp_bus.valid && rsp_bus.ready && rsp_bus.last, state_ff == fdl_pkg::ST_IDLE)

endmodule
`default_nettype wire
